// File: rtl/charge_phase_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Charge phase sequencer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CHARGE_PHASE_SEQUENCER_ASSERT_SVH
`define CHARGE_PHASE_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("charge phase sequencer: same-cycle check failed");

// Next-cycle implication
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("charge phase sequencer: next-cycle check failed");

`endif

// File: rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Types, codes and register defaults for the charge phase sequencer.
// ----------------------------------------------------------------------------
package cps_pkg;

    // Phase codes (off is reported by the loop, never entered here)
    typedef enum logic [2:0] {
        PH_PRE   = 3'd0,
        PH_CLOSE = 3'd1,
        PH_CC    = 3'd2,
        PH_CV    = 3'd3,
        PH_OFF   = 3'd4
    } t_phase;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_RAMP  = 2'd2,
        ACT_ABORT = 2'd3
    } t_action;

    // Request codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        REQ_STEP    = 2'd0,
        REQ_ADVANCE = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUAL_MODE  = 3'd0,
        CFG_SETTLE_LIMIT = 3'd1,
        CFG_STUCK_REF    = 3'd2,
        CFG_STUCK_MEAS   = 3'd3,
        CFG_STUCK_LIMIT  = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic               MANUAL_MODE_RST  = 1'b0;
    localparam logic        [15:0] SETTLE_LIMIT_RST = 16'd100;
    localparam logic signed [15:0] STUCK_REF_RST    = 16'sd500;
    localparam logic signed [15:0] STUCK_MEAS_RST   = 16'sd50;
    localparam logic        [15:0] STUCK_LIMIT_RST  = 16'd200;

    // Configuration as seen by the core
    typedef struct packed {
        logic               manual_mode;
        logic        [15:0] settle_limit_ms;
        logic signed [15:0] stuck_ref_ma;
        logic signed [15:0] stuck_meas_ma;
        logic        [15:0] stuck_limit_ms;
    } t_cfg;

    // One input word
    typedef struct packed {
        logic        [1:0]  req_type;
        logic        [2:0]  loop_phase;
        logic signed [15:0] ref_current_ma;
        logic signed [15:0] meas_current_ma;
        logic        [15:0] elapsed_ms;
    } t_item;

    // One result word
    typedef struct packed {
        logic [1:0] action;
        logic [2:0] phase_now;
        logic       awaiting_advance;
        logic       may_complete;
    } t_result;

endpackage

// File: rtl/charge_phase_sequencer.sv
// ----------------------------------------------------------------------------
// charge_phase_sequencer
// Battery charge phase sequencer: precharge, relay close, constant-current
// ramp and constant-voltage, with relay settle and stuck-open timers.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output channel does not stall; each word
// passes from the input register through the step logic into the result register,
// and the phase state updates as each word moves on.
// Reset: synchronous, active low; clears the phase, timers and flags and loads
// the register defaults (manual off, settle 100, ref 500, meas 50, stuck 200).
`include "charge_phase_sequencer_assert.svh"

module charge_phase_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [2:0]                      i_loop_phase,
    input  logic signed [15:0]              i_ref_current_ma,
    input  logic signed [15:0]              i_meas_current_ma,
    input  logic [15:0]                     i_elapsed_ms,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_action,
    output logic [2:0]                      o_phase_now,
    output logic                            o_awaiting_advance,
    output logic                            o_may_complete,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cps_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    cps_pkg::t_item   r_in;
    logic             r_out_valid;
    cps_pkg::t_result r_out;
    cps_pkg::t_result w_result;
    logic             w_out_ready;
    logic             w_fire;
    logic             w_in_accept;

    // Handshake: the input register drains when the result register is free
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manual_mode     <= cps_pkg::MANUAL_MODE_RST;
            r_cfg.settle_limit_ms <= cps_pkg::SETTLE_LIMIT_RST;
            r_cfg.stuck_ref_ma    <= cps_pkg::STUCK_REF_RST;
            r_cfg.stuck_meas_ma   <= cps_pkg::STUCK_MEAS_RST;
            r_cfg.stuck_limit_ms  <= cps_pkg::STUCK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cps_pkg::CFG_MANUAL_MODE:  r_cfg.manual_mode     <= i_cfg_data[0];
                cps_pkg::CFG_SETTLE_LIMIT: r_cfg.settle_limit_ms <= i_cfg_data;
                cps_pkg::CFG_STUCK_REF:    r_cfg.stuck_ref_ma    <= i_cfg_data;
                cps_pkg::CFG_STUCK_MEAS:   r_cfg.stuck_meas_ma   <= i_cfg_data;
                cps_pkg::CFG_STUCK_LIMIT:  r_cfg.stuck_limit_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in.req_type        <= i_req_type;
            r_in.loop_phase      <= i_loop_phase;
            r_in.ref_current_ma  <= i_ref_current_ma;
            r_in.meas_current_ma <= i_meas_current_ma;
            r_in.elapsed_ms      <= i_elapsed_ms;
        end
    end

    // Step logic and sequencer state
    cps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_action           = r_out.action;
    assign o_phase_now        = r_out.phase_now;
    assign o_awaiting_advance = r_out.awaiting_advance;
    assign o_may_complete     = r_out.may_complete;

    // Checks
    `CPS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n,
        w_fire, r_out_valid)
    `CPS_ASSERT_IMP(a_stall_needs_full_in, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_out_valid && i_out_stall)
    `CPS_ASSERT_IMP(a_empty_out_drains, i_clk, i_rst_n,
        r_in_valid && !r_out_valid, w_fire)

endmodule

// File: rtl/cps_core.sv
// ----------------------------------------------------------------------------
// cps_core
// Sequencer state and step logic: evaluates one word per enabled cycle,
// updates the phase, timers and advance flags, and forms the result.
// ----------------------------------------------------------------------------
`include "charge_phase_sequencer_assert.svh"

module cps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cps_pkg::t_item    i_item,
    input  cps_pkg::t_cfg     i_cfg,
    output cps_pkg::t_result  o_result
);

    cps_pkg::t_phase  r_phase,  n_phase;
    logic [15:0]      r_settle, n_settle;
    logic [15:0]      r_stuck,  n_stuck;
    logic             r_adv,    n_adv;
    logic             r_ready,  n_ready;
    cps_pkg::t_action w_act;

    logic [16:0] w_settle_sum;
    logic [15:0] w_settle_upd;
    logic [16:0] w_stuck_sum;
    logic [15:0] w_stuck_upd;
    logic        w_stuck_cond;

    // Saturating timer updates; a timer only counts while below its limit
    assign w_settle_sum = {1'b0, r_settle} + {1'b0, i_item.elapsed_ms};
    assign w_stuck_sum  = {1'b0, r_stuck} + {1'b0, i_item.elapsed_ms};

    always_comb begin
        w_settle_upd = r_settle;
        if (r_settle < i_cfg.settle_limit_ms) begin
            w_settle_upd = w_settle_sum[16] ? 16'hFFFF : w_settle_sum[15:0];
        end
        w_stuck_upd = r_stuck;
        if (r_stuck < i_cfg.stuck_limit_ms) begin
            w_stuck_upd = w_stuck_sum[16] ? 16'hFFFF : w_stuck_sum[15:0];
        end
    end

    // Reference high while measured current stays low: path looks open
    assign w_stuck_cond = (i_item.ref_current_ma > i_cfg.stuck_ref_ma) &&
                          (i_item.meas_current_ma < i_cfg.stuck_meas_ma);

    // Next state and action
    always_comb begin
        n_phase  = r_phase;
        n_settle = r_settle;
        n_stuck  = r_stuck;
        n_adv    = r_adv;
        n_ready  = r_ready;
        w_act    = cps_pkg::ACT_NONE;
        if (i_fire) begin
            case (i_item.req_type)
                cps_pkg::REQ_STEP: begin
                    case (r_phase)
                        cps_pkg::PH_PRE: begin
                            if (i_item.loop_phase == cps_pkg::PH_CLOSE) begin
                                n_ready = 1'b1;
                                if (!i_cfg.manual_mode || r_adv) begin
                                    n_adv    = 1'b0;
                                    n_ready  = 1'b0;
                                    n_phase  = cps_pkg::PH_CLOSE;
                                    n_settle = '0;
                                    w_act    = cps_pkg::ACT_CLOSE;
                                end
                            end
                        end
                        cps_pkg::PH_CLOSE: begin
                            n_settle = w_settle_upd;
                            if (w_settle_upd >= i_cfg.settle_limit_ms) begin
                                n_phase = cps_pkg::PH_CC;
                                n_stuck = '0;
                                w_act   = cps_pkg::ACT_RAMP;
                            end
                        end
                        cps_pkg::PH_CC: begin
                            if (i_item.loop_phase == cps_pkg::PH_CV) begin
                                n_phase = cps_pkg::PH_CV;
                                n_stuck = '0;
                            end else if (w_stuck_cond) begin
                                n_stuck = w_stuck_upd;
                                if (w_stuck_upd >= i_cfg.stuck_limit_ms) begin
                                    w_act = cps_pkg::ACT_ABORT;
                                end
                            end else begin
                                n_stuck = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                cps_pkg::REQ_ADVANCE: begin
                    n_adv = 1'b1;
                end
                cps_pkg::REQ_RESTART: begin
                    n_phase  = cps_pkg::PH_PRE;
                    n_settle = '0;
                    n_stuck  = '0;
                    n_adv    = 1'b0;
                    n_ready  = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Result from the post-item state
    always_comb begin
        o_result.action           = w_act;
        o_result.phase_now        = n_phase;
        o_result.awaiting_advance = i_cfg.manual_mode && n_ready && !n_adv;
        o_result.may_complete     = (n_phase == cps_pkg::PH_CC) ||
                                    (n_phase == cps_pkg::PH_CV);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cps_pkg::PH_PRE;
            r_settle <= '0;
            r_stuck  <= '0;
            r_adv    <= 1'b0;
            r_ready  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_settle <= n_settle;
            r_stuck  <= n_stuck;
            r_adv    <= n_adv;
            r_ready  <= n_ready;
        end
    end

    // Checks
    `CPS_ASSERT_NEXT(a_ramp_enters_cc, i_clk, i_rst_n,
        w_act == cps_pkg::ACT_RAMP, r_phase == cps_pkg::PH_CC)
    `CPS_ASSERT_IMP(a_abort_only_in_cc, i_clk, i_rst_n,
        w_act == cps_pkg::ACT_ABORT, r_phase == cps_pkg::PH_CC)
    `CPS_ASSERT_IMP(a_ready_only_in_pre, i_clk, i_rst_n,
        r_phase != cps_pkg::PH_PRE, !r_ready)
    `CPS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n,
        i_fire && (i_item.req_type == cps_pkg::REQ_RESTART),
        (r_phase == cps_pkg::PH_PRE) && (r_settle == '0) && (r_stuck == '0) && !r_adv)

endmodule
